[src/sacq_pkg.sv]
// Shared constants, types and helpers of the set-associative cache model.
package sacq_pkg;

    localparam int MAX_SETS  = 64;
    localparam int MAX_WAYS  = 8;
    localparam int ADDR_W    = 64;
    localparam int SET_W     = $clog2(MAX_SETS);
    localparam int WAY_W     = $clog2(MAX_WAYS);
    localparam int WAYS_W    = 4;
    localparam int SB_W      = 3;
    localparam int BB_W      = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 8;
    localparam int CNT_W     = 32;
    localparam int SHIFT_W   = 6;

    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_STORE  = 2'd1,
        CMD_MODIFY = 2'd2,
        CMD_IFETCH = 2'd3
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SET_BITS   = 2'd0,
        REG_BLOCK_BITS = 2'd1,
        REG_WAYS       = 2'd2,
        REG_UNUSED     = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_READ = 2'd1,
        ST_LOOK = 2'd2
    } back_state_t;

    typedef struct packed {
        logic [SB_W-1:0]   set_bits;
        logic [BB_W-1:0]   block_bits;
        logic [WAYS_W-1:0] ways;
    } cfg_t;

    typedef struct packed {
        logic              modify;
        logic [SET_W-1:0]  set_idx;
        logic [ADDR_W-1:0] tag;
    } req_t;

    // Queue head as seen by the back end.
    typedef struct packed {
        logic valid;
        req_t req;
    } head_t;

    // Ways in use: zero counts as one, large values saturate.
    function automatic logic [WAYS_W-1:0] eff_ways(input logic [WAYS_W-1:0] w);
        logic [WAYS_W-1:0] r;
        r = w;
        if (w == '0)
        begin
            r = WAYS_W'(1);
        end
        else if (w > WAYS_W'(MAX_WAYS))
        begin
            r = WAYS_W'(MAX_WAYS);
        end
        return r;
    endfunction

endpackage

[src/sacq_ifs.sv]
// Handshake interfaces of the request, result and configuration channels.
interface sacq_req_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     cmd;
    logic [sacq_pkg::ADDR_W-1:0]    address;
    modport source (output valid, output cmd, output address, input ready);
    modport sink (input valid, input cmd, input address, output ready);
endinterface

interface sacq_rsp_if;
    logic                           valid;
    logic                           ready;
    logic                           hit;
    logic                           evicted;
    logic [sacq_pkg::CNT_W-1:0]     hit_total;
    logic [sacq_pkg::CNT_W-1:0]     miss_total;
    logic [sacq_pkg::CNT_W-1:0]     evict_total;
    logic                           last;
    modport source (output valid, output hit, output evicted, output hit_total,
                    output miss_total, output evict_total, output last, input ready);
    modport sink (input valid, input hit, input evicted, input hit_total,
                  input miss_total, input evict_total, input last, output ready);
endinterface

interface sacq_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [sacq_pkg::CFG_IDX_W-1:0]   index;
    logic [sacq_pkg::CFG_DAT_W-1:0]   data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

[src/sacq_front.sv]
// Front end: splits the address into set and tag and queues the accesses.
module sacq_front (
    input  logic                clk,
    input  logic                rst_n,
    sacq_req_if.sink            req,
    input  sacq_pkg::cfg_t      cfg,
    output sacq_pkg::head_t     head,
    input  logic                pop
);
    import sacq_pkg::*;

    localparam int DEPTH = 2;

    req_t              ent_reg [DEPTH];
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic [1:0]        count_reg;
    logic [1:0]        count_next;
    logic              push;
    logic              do_pop;
    logic [SB_W+3:0]   set_mask;
    logic [ADDR_W-1:0] line_addr;
    req_t              new_req;

    always_comb
    begin
        set_mask  = (SB_W+4)'((SB_W+4)'(1) << cfg.set_bits) - (SB_W+4)'(1);
        line_addr = req.address >> cfg.block_bits;
        new_req.modify  = (req.cmd == CMD_MODIFY);
        new_req.set_idx = line_addr[SET_W-1:0] & set_mask[SET_W-1:0];
        new_req.tag     = req.address >> (SHIFT_W'(cfg.set_bits) + SHIFT_W'(cfg.block_bits));
    end

    assign req.ready = (count_reg != 2'(DEPTH));
    // Instruction fetches are accepted but make no access.
    assign push      = req.valid && req.ready && (req.cmd != CMD_IFETCH);
    assign do_pop    = pop && (count_reg != '0);
    assign head.valid = (count_reg != '0);
    assign head.req   = ent_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= new_req;
        end
    end

endmodule

[src/sacq_back.sv]
// Back end: reads a set, decides hit or fill, updates the set and reports.
module sacq_back (
    input  logic                clk,
    input  logic                rst_n,
    input  sacq_pkg::cfg_t      cfg,
    input  sacq_pkg::head_t     head,
    output logic                pop,
    sacq_rsp_if.source          rsp
);
    import sacq_pkg::*;

    localparam int ORD_W = MAX_WAYS * WAY_W;

    back_state_t       state_reg;
    back_state_t       state_next;
    logic              second_reg;
    req_t              cur_reg;

    logic [MAX_WAYS-1:0] vld_mem [MAX_SETS];
    logic [ORD_W-1:0]    ord_mem [MAX_SETS];
    logic [ADDR_W-1:0]   tag_mem [MAX_SETS][MAX_WAYS];
    logic [MAX_WAYS-1:0] vld_rd_reg;
    logic [ORD_W-1:0]    ord_rd_reg;
    logic [ADDR_W-1:0]   tag_rd_reg [MAX_WAYS];
    logic [MAX_SETS-1:0] touched_reg;

    logic [CNT_W-1:0]  hits_reg;
    logic [CNT_W-1:0]  misses_reg;
    logic [CNT_W-1:0]  evicts_reg;

    logic              out_valid_reg;
    logic              out_hit_reg;
    logic              out_ev_reg;
    logic              out_last_reg;

    logic              out_free;
    logic              fire;
    logic [WAYS_W-1:0] w;
    logic [WAY_W-1:0]  w_last;
    logic [MAX_WAYS-1:0] vrow;
    logic [WAY_W-1:0]  ord [MAX_WAYS];
    logic [WAY_W-1:0]  new_ord [MAX_WAYS];
    logic [ORD_W-1:0]  new_ord_flat;
    logic [MAX_WAYS-1:0] new_vrow;
    logic              hit;
    logic              has_inv;
    logic              found;
    logic [WAY_W-1:0]  hit_way;
    logic [WAY_W-1:0]  inv_way;
    logic [WAY_W-1:0]  victim;
    logic [WAY_W-1:0]  fill_way;
    logic [WAY_W-1:0]  front_way;
    logic [WAY_W-1:0]  pos;
    logic [WAY_W-1:0]  p;

    assign out_free = !out_valid_reg || rsp.ready;
    assign fire     = (state_reg == ST_LOOK) && out_free;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (head.valid)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_LOOK;
            end
            ST_LOOK:
            begin
                if (fire)
                begin
                    state_next = (cur_reg.modify && !second_reg) ? ST_READ : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer.
    always_comb
    begin
        pop = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                pop = head.valid;
            end
            ST_READ, ST_LOOK:
            begin
                pop = 1'b0;
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    // Lookup and recency update of the set just read.
    always_comb
    begin
        w      = eff_ways(cfg.ways);
        w_last = WAY_W'(w - WAYS_W'(1));
        // A set never written since reset reads as all invalid with a zero order.
        vrow   = touched_reg[cur_reg.set_idx] ? vld_rd_reg : '0;
        for (int i = 0; i < MAX_WAYS; i++)
        begin
            ord[i] = touched_reg[cur_reg.set_idx] ? ord_rd_reg[i*WAY_W +: WAY_W] : '0;
        end
        hit     = 1'b0;
        has_inv = 1'b0;
        hit_way = '0;
        inv_way = '0;
        for (int i = 0; i < MAX_WAYS; i++)
        begin
            if (WAYS_W'(i) < w)
            begin
                if (vrow[i] && (tag_rd_reg[i] == cur_reg.tag))
                begin
                    hit     = 1'b1;
                    hit_way = WAY_W'(i);
                end
                if (!vrow[i])
                begin
                    has_inv = 1'b1;
                    inv_way = WAY_W'(i);
                end
            end
        end
        found = 1'b0;
        pos   = w_last;
        for (int i = 0; i < MAX_WAYS; i++)
        begin
            if (!found && (WAYS_W'(i) < w) && (ord[i] == hit_way))
            begin
                found = 1'b1;
                pos   = WAY_W'(i);
            end
        end
        victim = ord[w_last];
        if (WAYS_W'(victim) >= w)
        begin
            victim = w_last;
        end
        fill_way  = has_inv ? inv_way : victim;
        front_way = hit ? hit_way : fill_way;
        p         = hit ? pos : w_last;
        new_ord[0] = front_way;
        for (int i = 1; i < MAX_WAYS; i++)
        begin
            new_ord[i] = (WAY_W'(i) <= p) ? ord[i-1] : ord[i];
        end
        for (int i = 0; i < MAX_WAYS; i++)
        begin
            new_ord_flat[i*WAY_W +: WAY_W] = new_ord[i];
        end
        new_vrow = vrow;
        if (!hit && has_inv)
        begin
            new_vrow[inv_way] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            second_reg    <= 1'b0;
            touched_reg   <= '0;
            hits_reg      <= '0;
            misses_reg    <= '0;
            evicts_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_IDLE)
            begin
                second_reg <= 1'b0;
            end
            else if (fire)
            begin
                second_reg <= 1'b1;
            end
            if (fire)
            begin
                out_valid_reg <= 1'b1;
                touched_reg[cur_reg.set_idx] <= 1'b1;
                if (hit)
                begin
                    hits_reg <= hits_reg + CNT_W'(1);
                end
                else
                begin
                    misses_reg <= misses_reg + CNT_W'(1);
                    if (!has_inv)
                    begin
                        evicts_reg <= evicts_reg + CNT_W'(1);
                    end
                end
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers and the set memories.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= head.req;
        end
        vld_rd_reg <= vld_mem[cur_reg.set_idx];
        ord_rd_reg <= ord_mem[cur_reg.set_idx];
        tag_rd_reg <= tag_mem[cur_reg.set_idx];
        if (fire)
        begin
            vld_mem[cur_reg.set_idx] <= new_vrow;
            ord_mem[cur_reg.set_idx] <= new_ord_flat;
            if (!hit)
            begin
                tag_mem[cur_reg.set_idx][fill_way] <= cur_reg.tag;
            end
            out_hit_reg  <= hit;
            out_ev_reg   <= !hit && !has_inv;
            out_last_reg <= !cur_reg.modify || second_reg;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.hit         = out_hit_reg;
    assign rsp.evicted     = out_ev_reg;
    assign rsp.hit_total   = hits_reg;
    assign rsp.miss_total  = misses_reg;
    assign rsp.evict_total = evicts_reg;
    assign rsp.last        = out_last_reg;

endmodule

[src/set_assoc_lru_cache_sim.sv]
// Top level of the tag-only set-associative cache with true LRU replacement.
//
//   channel | role   | beat
//   req     | sink   | cmd, address
//   rsp     | source | hit, evicted, hit_total, miss_total, evict_total, last
//   cfg     | sink   | index, data (always ready)
//
// A load or store passes through the take, set read and update steps of the
// back end; a modify repeats the set read and update, as its second access
// rereads the updated set. The two-beat queue lets the front take requests
// while the back end works or waits on a stalled result beat.
// After reset no clearing pass is needed: a per-set written flag hides stale rows.
module set_assoc_lru_cache_sim (
    input  logic        clk,
    input  logic        rst_n,
    sacq_req_if.sink    req,
    sacq_rsp_if.source  rsp,
    sacq_cfg_if.sink    cfg
);
    import sacq_pkg::*;

    cfg_t  cfg_reg;
    head_t head;
    logic  pop;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.set_bits   <= '0;
            cfg_reg.block_bits <= '0;
            cfg_reg.ways       <= WAYS_W'(1);
        end
        else if (cfg.valid)
        begin
            case (reg_idx_t'(cfg.index))
                REG_SET_BITS:   cfg_reg.set_bits   <= cfg.data[SB_W-1:0];
                REG_BLOCK_BITS: cfg_reg.block_bits <= cfg.data[BB_W-1:0];
                REG_WAYS:       cfg_reg.ways       <= cfg.data[WAYS_W-1:0];
                default:        cfg_reg            <= cfg_reg;
            endcase
        end
    end

    sacq_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cfg   (cfg_reg),
        .head  (head),
        .pop   (pop)
    );

    sacq_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_reg),
        .head  (head),
        .pop   (pop),
        .rsp   (rsp)
    );

endmodule
